// ----- src/ssm_pkg.sv -----
package ssm_pkg;

    // Kind of symbol carried on the input tuser line.
    localparam logic MODE_PATTERN = 1'b0;
    localparam logic MODE_TEXT    = 1'b1;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_FOUND     = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_TOO_LONG  = 2'd2
    } status_t;

    // Control part of one input word.
    typedef struct packed {
        logic mode;
        logic last;
    } item_ctl_t;

endpackage

// ----- src/ssm_in_stage.sv -----
module ssm_in_stage #(
    parameter int SYMBOL_BITS = 8
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [SYMBOL_BITS-1:0] s_symbol,
    input  ssm_pkg::item_ctl_t     s_ctl,
    input  logic                   take,
    output logic                   item_valid,
    output logic [SYMBOL_BITS-1:0] item_symbol,
    output ssm_pkg::item_ctl_t     item_ctl
);

    logic                   valid_reg;
    logic                   valid_next;
    logic [SYMBOL_BITS-1:0] symbol_reg;
    ssm_pkg::item_ctl_t     ctl_reg;

    // The register may be refilled in the same cycle that the core takes its word.
    assign s_tready   = !valid_reg || take;
    assign valid_next = (s_tvalid && s_tready) || (valid_reg && !take);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            symbol_reg <= s_symbol;
            ctl_reg    <= s_ctl;
        end
    end

    assign item_valid  = valid_reg;
    assign item_symbol = symbol_reg;
    assign item_ctl    = ctl_reg;

endmodule

// ----- src/ssm_match_core.sv -----
module ssm_match_core #(
    parameter int MAX_PATTERN   = 16,
    parameter int SYMBOL_BITS   = 8,
    parameter int POSITION_BITS = 16
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     item_valid,
    input  logic [SYMBOL_BITS-1:0]   item_symbol,
    input  ssm_pkg::item_ctl_t       item_ctl,
    output logic                     take,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output ssm_pkg::status_t         m_status,
    output logic [POSITION_BITS-1:0] m_position
);

    localparam int LEN_W = $clog2(MAX_PATTERN + 1);
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_PATTERN);
    localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

    // Pattern and window are both held with the newest symbol at the top lane,
    // so pattern symbol i of a pattern of length n sits in lane MAX_PATTERN-n+i,
    // exactly where the window holds the matching text symbol.
    logic [SYMBOL_BITS-1:0]   pat_reg   [MAX_PATTERN];
    logic [SYMBOL_BITS-1:0]   win_reg   [MAX_PATTERN];
    logic [SYMBOL_BITS-1:0]   win_shift [MAX_PATTERN];
    logic [MAX_PATTERN-1:0]   lane_ok;

    logic [LEN_W-1:0]         len_reg,   len_next;
    logic                     ovf_reg,   ovf_next;
    logic                     load_reg,  load_next;
    logic [LEN_W-1:0]         fill_reg,  fill_next;
    logic [POSITION_BITS-1:0] index_reg, index_next;
    logic                     done_reg,  done_next;
    logic                     out_valid_reg, out_valid_next;
    ssm_pkg::status_t         status_reg, status_next;
    logic [POSITION_BITS-1:0] pos_reg,    pos_next;

    logic                     pat_shift_en;
    logic                     win_shift_en;
    logic                     res_load;
    logic                     sym_zero;
    logic                     text_ends;
    logic [LEN_W-1:0]         len_base;
    logic [LEN_W-1:0]         fill_inc;
    logic                     window_hit;
    logic [POSITION_BITS-1:0] found_pos;

    // A word is taken when the result register is free or being emptied.
    assign take = item_valid && (!out_valid_reg || m_tready);

    // Window as it stands after the current text symbol is shifted in.
    generate
        for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_lane
            if (k < MAX_PATTERN - 1) begin : g_mid
                assign win_shift[k] = win_reg[k+1];
            end else begin : g_top
                assign win_shift[k] = item_symbol;
            end
            // Lanes below the pattern's start take no part in the compare.
            assign lane_ok[k] = ((k + int'(len_reg)) < MAX_PATTERN)
                                || (win_shift[k] == pat_reg[k]);
        end
    endgenerate

    assign sym_zero   = (item_symbol == '0);
    assign text_ends  = item_ctl.last || sym_zero;
    assign len_base   = load_reg ? len_reg : '0;
    assign fill_inc   = (fill_reg < LEN_MAX) ? fill_reg + LEN_W'(1) : fill_reg;
    assign window_hit = (len_reg != '0) && (fill_inc >= len_reg) && (&lane_ok);
    assign found_pos  = (index_reg == POS_MAX) ? POS_MAX
                        : index_reg - POSITION_BITS'(len_reg) + POSITION_BITS'(1);

    // Next state and result for the word being taken.
    always_comb begin
        len_next       = len_reg;
        ovf_next       = ovf_reg;
        load_next      = load_reg;
        fill_next      = fill_reg;
        index_next     = index_reg;
        done_next      = done_reg;
        pat_shift_en   = 1'b0;
        win_shift_en   = 1'b0;
        res_load       = 1'b0;
        status_next    = ssm_pkg::ST_NOT_FOUND;
        pos_next       = '0;
        out_valid_next = out_valid_reg && !m_tready;

        if (take) begin
            if (item_ctl.mode == ssm_pkg::MODE_PATTERN) begin
                // A pattern word while not loading starts a new pattern and drops the text.
                if (!load_reg) begin
                    ovf_next   = 1'b0;
                    fill_next  = '0;
                    index_next = '0;
                    done_next  = 1'b0;
                end
                len_next = len_base;
                if (sym_zero) begin
                    load_next = 1'b0;
                end else begin
                    if (len_base < LEN_MAX) begin
                        pat_shift_en = 1'b1;
                        len_next     = len_base + LEN_W'(1);
                    end else begin
                        ovf_next = 1'b1;
                    end
                    load_next = !item_ctl.last;
                end
            end else begin
                load_next = 1'b0;
                if (done_reg) begin
                    // Text after a result is skipped until it ends.
                    if (text_ends) begin
                        fill_next  = '0;
                        index_next = '0;
                        done_next  = 1'b0;
                    end
                end else if (ovf_reg || len_reg == '0) begin
                    res_load    = 1'b1;
                    status_next = ovf_reg ? ssm_pkg::ST_TOO_LONG : ssm_pkg::ST_NOT_FOUND;
                    if (text_ends) begin
                        fill_next  = '0;
                        index_next = '0;
                    end else begin
                        done_next = 1'b1;
                    end
                end else if (sym_zero) begin
                    res_load   = 1'b1;
                    fill_next  = '0;
                    index_next = '0;
                end else begin
                    win_shift_en = 1'b1;
                    fill_next    = fill_inc;
                    if (index_reg != POS_MAX) begin
                        index_next = index_reg + POSITION_BITS'(1);
                    end
                    if (window_hit) begin
                        res_load    = 1'b1;
                        status_next = ssm_pkg::ST_FOUND;
                        pos_next    = found_pos;
                    end else if (item_ctl.last) begin
                        res_load = 1'b1;
                    end
                    if (item_ctl.last) begin
                        fill_next  = '0;
                        index_next = '0;
                    end else if (window_hit) begin
                        done_next = 1'b1;
                    end
                end
            end
            if (res_load) begin
                out_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg       <= '0;
            ovf_reg       <= 1'b0;
            load_reg      <= 1'b0;
            fill_reg      <= '0;
            index_reg     <= '0;
            done_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            len_reg       <= len_next;
            ovf_reg       <= ovf_next;
            load_reg      <= load_next;
            fill_reg      <= fill_next;
            index_reg     <= index_next;
            done_reg      <= done_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Pattern store, window and result payload carry no reset.
    always_ff @(posedge aclk) begin
        if (pat_shift_en) begin
            for (int k = 0; k < MAX_PATTERN - 1; k++) begin
                pat_reg[k] <= pat_reg[k+1];
            end
            pat_reg[MAX_PATTERN-1] <= item_symbol;
        end
        if (win_shift_en) begin
            for (int k = 0; k < MAX_PATTERN; k++) begin
                win_reg[k] <= win_shift[k];
            end
        end
        if (res_load) begin
            status_reg <= status_next;
            pos_reg    <= pos_next;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_status   = status_reg;
    assign m_position = pos_reg;

endmodule

// ----- src/substring_first_match.sv -----
// First-occurrence substring search over a symbol stream.
// Input words arrive on the s_ channel: tuser gives the kind (0 pattern
// symbol, 1 text symbol), tdata the symbol and tlast the final symbol of a
// pattern or of a text. Load the pattern first; a zero symbol also ends it.
// Text symbols then stream in and are compared against the stored pattern
// in a sliding window, all lanes in parallel.
// A text that ends yields one result word on m_: found with the start position,
// not found (at its end, if a pattern is stored) or pattern too long.
// From input acceptance to m_tvalid a word passes one input register, then
// the window compare feeding the result register. Throughput is one word
// per cycle while no result waits on a low m_tready, set by the combinational
// window compare and the state update that the next word relies on.
// While a result is held by a low m_tready, the input register still
// accepts one word, after which s_tready falls until the result is taken.
// Reset clears the pattern length, window fill, index and handshake state;
// a text sent before any pattern reports not found.
module substring_first_match #(
    parameter int MAX_PATTERN   = 16,
    parameter int SYMBOL_BITS   = 8,
    parameter int POSITION_BITS = 16,
    localparam int S_DATA_W = ((SYMBOL_BITS + 7) / 8) * 8,
    localparam int M_DATA_W = ((POSITION_BITS + 2 + 7) / 8) * 8
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // symbol
    input  logic                s_tuser,   // mode
    input  logic                s_tlast,   // last
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata    // status, position
);

    logic                     item_valid;
    logic                     take;
    logic [SYMBOL_BITS-1:0]   item_symbol;
    ssm_pkg::item_ctl_t       s_ctl;
    ssm_pkg::item_ctl_t       item_ctl;
    ssm_pkg::status_t         res_status;
    logic [POSITION_BITS-1:0] res_position;

    assign s_ctl.mode = s_tuser;
    assign s_ctl.last = s_tlast;

    ssm_in_stage #(
        .SYMBOL_BITS (SYMBOL_BITS)
    ) u_in_stage (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_symbol    (s_tdata[SYMBOL_BITS-1:0]),
        .s_ctl       (s_ctl),
        .take        (take),
        .item_valid  (item_valid),
        .item_symbol (item_symbol),
        .item_ctl    (item_ctl)
    );

    ssm_match_core #(
        .MAX_PATTERN   (MAX_PATTERN),
        .SYMBOL_BITS   (SYMBOL_BITS),
        .POSITION_BITS (POSITION_BITS)
    ) u_match_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .item_valid  (item_valid),
        .item_symbol (item_symbol),
        .item_ctl    (item_ctl),
        .take        (take),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_status    (res_status),
        .m_position  (res_position)
    );

    // Result word: status in the low bits, position above, zero padding on top.
    assign m_tdata = M_DATA_W'({res_position, res_status});

`ifndef SYNTHESIS
    // The core only takes a word that the input register holds.
    assert property (@(posedge aclk) disable iff (!aresetn) take |-> item_valid)
        else $error("core took a word from an empty input register");

    // A stalled result is never overwritten by a new word.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |-> !take)
        else $error("stalled result overwritten");

    // Only a found result carries a position.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && res_status != ssm_pkg::ST_FOUND) |-> (res_position == '0))
        else $error("position set on a result that is not found");
`endif

endmodule

// ----- sim/tb_substring_first_match.sv -----
module tb_substring_first_match;

    localparam int PAT_MAX = 16;
    localparam int POS_MAX = 65535;

    typedef logic [7:0] sym_q_t [$];
    typedef enum {END_LAST, END_ZERO, END_OPEN} run_end_t;

    typedef struct packed {
        ssm_pkg::status_t status;
        logic [15:0]      position;
    } search_result_t;

    // Tracks pattern and text state as the block should, and holds the
    // results that are still owed on the m_ channel.
    class first_match_scoreboard;
        logic [7:0]     pattern_syms [PAT_MAX];
        int unsigned    pattern_len;
        bit             too_long;
        bit             loading;
        logic [7:0]     window [PAT_MAX];
        int unsigned    fill;
        int unsigned    text_pos;
        bit             reported;
        search_result_t awaited_results [$];
        int unsigned    mismatches;
        int unsigned    found_count;
        int unsigned    miss_count;
        int unsigned    long_count;

        function new();
            pattern_len = 0;
            too_long    = 0;
            loading     = 0;
            mismatches  = 0;
            found_count = 0;
            miss_count  = 0;
            long_count  = 0;
            clear_text();
        endfunction

        function void clear_text();
            foreach (window[i]) window[i] = 8'h00;
            fill     = 0;
            text_pos = 0;
            reported = 0;
        endfunction

        function void owe_result(ssm_pkg::status_t st, logic [15:0] pos);
            search_result_t r;
            r.status   = st;
            r.position = pos;
            awaited_results.push_back(r);
        endfunction

        // Updates the state for one accepted input word. Returns 0 for a text
        // symbol that is merely skipped after the text has already reported.
        function bit note_symbol(logic mode, logic [7:0] sym, logic last);
            bit          ends;
            bit          hit;
            int unsigned cur;
            if (mode == ssm_pkg::MODE_PATTERN) begin
                // The first pattern symbol drops the old pattern and any text.
                if (!loading) begin
                    pattern_len = 0;
                    too_long    = 0;
                    loading     = 1;
                    clear_text();
                end
                if (sym == 8'h00) begin
                    loading = 0;
                    return 1;
                end
                if (pattern_len < PAT_MAX) begin
                    pattern_syms[pattern_len] = sym;
                    pattern_len++;
                end else begin
                    too_long = 1;
                end
                if (last) loading = 0;
                return 1;
            end

            loading = 0;
            ends    = last || (sym == 8'h00);

            if (reported) begin
                if (ends) clear_text();
                return 0;
            end

            // No usable pattern: the first text symbol reports at once.
            if (too_long || pattern_len == 0) begin
                owe_result(too_long ? ssm_pkg::ST_TOO_LONG : ssm_pkg::ST_NOT_FOUND, 16'd0);
                if (ends) clear_text();
                else reported = 1;
                return 1;
            end

            if (sym == 8'h00) begin
                owe_result(ssm_pkg::ST_NOT_FOUND, 16'd0);
                clear_text();
                return 1;
            end

            // Shift the symbol into the window and compare its tail.
            for (int i = 0; i + 1 < PAT_MAX; i++) window[i] = window[i + 1];
            window[PAT_MAX - 1] = sym;
            if (fill < PAT_MAX) fill++;
            cur = text_pos;
            if (text_pos < POS_MAX) text_pos++;

            hit = (fill >= pattern_len);
            for (int i = 0; i < pattern_len; i++) begin
                if (window[PAT_MAX - pattern_len + i] != pattern_syms[i]) hit = 0;
            end

            if (hit) begin
                owe_result(ssm_pkg::ST_FOUND,
                           (cur >= POS_MAX) ? 16'(POS_MAX) : 16'(cur - (pattern_len - 1)));
                if (last) clear_text();
                else reported = 1;
                return 1;
            end

            if (last) begin
                owe_result(ssm_pkg::ST_NOT_FOUND, 16'd0);
                clear_text();
            end
            return 1;
        endfunction

        task report_mismatch(string what);
            $display("error at %0t: %s", $realtime, what);
            mismatches++;
        endtask

        // Compares one accepted result word with the oldest owed result.
        task check_result(logic [23:0] word);
            search_result_t want;
            if (awaited_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result, status %0d position %0d",
                                          word[1:0], word[17:2]));
                return;
            end
            want = awaited_results.pop_front();
            if (word[1:0] !== want.status)
                report_mismatch($sformatf("status %0d, wanted %0d", word[1:0], want.status));
            if (word[17:2] !== want.position)
                report_mismatch($sformatf("position %0d, wanted %0d",
                                          word[17:2], want.position));
            case (want.status)
                ssm_pkg::ST_FOUND:     found_count++;
                ssm_pkg::ST_NOT_FOUND: miss_count++;
                default:               long_count++;
            endcase
        endtask
    endclass

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [7:0]  s_tdata  = 8'h00;
    logic        s_tuser  = 1'b0;
    logic        s_tlast  = 1'b0;
    logic        m_tready = 1'b1;
    logic        s_tready;
    logic        m_tvalid;
    logic [23:0] m_tdata;

    first_match_scoreboard board = new();

    int unsigned counted     = 0;
    int unsigned in_gap_pct  = 0;
    int unsigned out_gap_pct = 0;

    substring_first_match i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // Result side: random bursts of back-pressure.
    initial begin
        forever begin
            @(posedge aclk);
            if (out_gap_pct != 0 && $urandom_range(0, 99) < out_gap_pct) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge aclk);
                m_tready <= 1'b1;
            end
        end
    end

    // Every result word taken is checked against the oldest owed one.
    initial begin
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) board.check_result(m_tdata);
        end
    end

    initial begin
        #4000000;
        $display("timeout with %0d results still owed", board.awaited_results.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Offers one word and waits for it to be taken; may then leave a gap.
    task automatic push_word(input logic mode, input logic [7:0] sym, input logic lst);
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= sym;
        s_tlast  <= lst;
        do @(posedge aclk); while (!s_tready);
        void'(board.note_symbol(mode, sym, lst));
        counted++;
        if (in_gap_pct != 0 && $urandom_range(0, 99) < in_gap_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge aclk);
        end
    endtask

    // Sends a pattern or a text, ended by tlast, by a zero symbol or not at all.
    task automatic send_run(input logic mode, input sym_q_t syms, input run_end_t how);
        foreach (syms[i]) push_word(mode, syms[i], how == END_LAST && i == syms.size() - 1);
        if (how == END_ZERO) push_word(mode, 8'h00, 1'($urandom_range(0, 1)));
    endtask

    // Holds the sender back until every owed result has come out.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (board.awaited_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    function automatic logic [7:0] pick(sym_q_t alpha);
        return alpha[$urandom_range(0, alpha.size() - 1)];
    endfunction

    // One pattern followed by a few texts drawn from a small alphabet, with
    // the pattern planted now and then and a little noise mixed in.
    task automatic random_scene();
        sym_q_t   alpha;
        sym_q_t   pat;
        sym_q_t   txt;
        int       plen;
        int       tlen;
        int       at;
        int       r;
        run_end_t how;
        repeat ($urandom_range(1, 4)) alpha.push_back(8'($urandom_range(1, 255)));

        r = $urandom_range(0, 99);
        if (r < 4) plen = 0;
        else if (r < 10) plen = $urandom_range(17, 20);
        else if (r < 25) plen = $urandom_range(5, 16);
        else plen = $urandom_range(1, 4);
        for (int i = 0; i < plen; i++) begin
            if ($urandom_range(0, 19) == 0) pat.push_back(8'($urandom_range(1, 255)));
            else pat.push_back(pick(alpha));
        end
        r = $urandom_range(0, 99);
        if (plen == 0 || (r >= 70 && r < 85)) how = END_ZERO;
        else if (r >= 85) how = END_OPEN;
        else how = END_LAST;
        send_run(ssm_pkg::MODE_PATTERN, pat, how);

        repeat ($urandom_range(1, 4)) begin
            txt.delete();
            tlen = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 60) : $urandom_range(1, 24);
            for (int i = 0; i < tlen; i++) begin
                if ($urandom_range(0, 32) == 0) txt.push_back(8'($urandom_range(0, 255)));
                else txt.push_back(pick(alpha));
            end
            if (plen >= 1 && plen <= tlen && $urandom_range(0, 99) < 40) begin
                at = $urandom_range(0, tlen - plen);
                for (int i = 0; i < plen; i++) txt[at + i] = pat[i];
            end
            r = $urandom_range(0, 99);
            if (r < 70) how = END_LAST;
            else if (r < 90) how = END_ZERO;
            else how = END_OPEN;
            send_run(ssm_pkg::MODE_TEXT, txt, how);
        end
    endtask

    initial begin
        sym_q_t      none;
        sym_q_t      pat;
        sym_q_t      txt;
        int unsigned next_drain;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed words. Text before any pattern sees an empty pattern.
        send_run(ssm_pkg::MODE_TEXT, {8'h41}, END_LAST);
        send_run(ssm_pkg::MODE_PATTERN, {8'hFF, 8'h01}, END_LAST);
        send_run(ssm_pkg::MODE_TEXT, {8'h01, 8'hFF, 8'h01}, END_LAST);
        // A zero symbol ends the text without a match.
        send_run(ssm_pkg::MODE_TEXT, {8'hFF, 8'h55}, END_ZERO);
        // After a match the rest of the text is skipped up to its last word.
        send_run(ssm_pkg::MODE_TEXT, {8'hFF, 8'h01, 8'h33}, END_LAST);
        send_run(ssm_pkg::MODE_TEXT, {8'h01}, END_LAST);
        // A zero symbol closes the pattern without being stored.
        send_run(ssm_pkg::MODE_PATTERN, {8'h7E}, END_ZERO);
        send_run(ssm_pkg::MODE_TEXT, {8'h80, 8'h7E}, END_LAST);
        // A text symbol closes a pattern that is still loading.
        send_run(ssm_pkg::MODE_PATTERN, {8'h10, 8'h20}, END_OPEN);
        send_run(ssm_pkg::MODE_TEXT, {8'h10, 8'h20}, END_LAST);
        // A new pattern abandons the text in progress.
        send_run(ssm_pkg::MODE_TEXT, {8'h10}, END_OPEN);
        send_run(ssm_pkg::MODE_PATTERN, {8'h20}, END_LAST);
        send_run(ssm_pkg::MODE_TEXT, {8'h20}, END_LAST);
        // An empty pattern reports on the first text symbol.
        send_run(ssm_pkg::MODE_PATTERN, none, END_ZERO);
        send_run(ssm_pkg::MODE_TEXT, {8'h61, 8'h62}, END_LAST);
        drain_results();

        // A pattern one symbol too long, then one of exactly the maximum length.
        for (int i = 0; i <= PAT_MAX; i++) pat.push_back(8'($urandom_range(1, 255)));
        send_run(ssm_pkg::MODE_PATTERN, pat, END_LAST);
        send_run(ssm_pkg::MODE_TEXT, {8'h11, 8'h22}, END_OPEN);
        send_run(ssm_pkg::MODE_TEXT, {8'h33}, END_LAST);
        void'(pat.pop_back());
        send_run(ssm_pkg::MODE_PATTERN, pat, END_LAST);
        txt = {8'h01, 8'h02, 8'h03};
        foreach (pat[i]) txt.push_back(pat[i]);
        send_run(ssm_pkg::MODE_TEXT, txt, END_LAST);
        drain_results();

        // Random scenes; pauses now and then, and a calm stretch at the end.
        next_drain = 400;
        while (counted < 1850) begin
            if (counted > 1550) begin
                in_gap_pct  = 0;
                out_gap_pct = 0;
            end else begin
                in_gap_pct  = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 60);
                out_gap_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 60);
            end
            random_scene();
            if (counted >= next_drain) begin
                drain_results();
                next_drain += 400;
            end
        end

        drain_results();
        repeat (12) @(posedge aclk);
        $display("sent %0d words: directed corner cases, then random patterns and texts",
                 counted);
        $display("results checked: %0d found, %0d not found, %0d pattern too long",
                 board.found_count, board.miss_count, board.long_count);
        if (board.mismatches == 0 && board.awaited_results.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
